// ===== rtl/core/kmd_pkg.sv =====
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;

    localparam logic       OP_SAMPLE      = 1'b0;
    localparam logic       OP_MAP_WRITE   = 1'b1;

    localparam logic [1:0] EV_NONE        = 2'd0;
    localparam logic [1:0] EV_PRESS       = 2'd1;
    localparam logic [1:0] EV_RELEASE     = 2'd2;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd18;
    localparam logic [4:0] ACTIVE_MAX     = 5'd31;

    typedef struct packed {
        logic        op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        key_down;
        logic [31:0] now_ms;
        logic [7:0]  map_code;
    } sample_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  key_code;
        logic [4:0]  active_count;
        logic [15:0] press_total;
    } result_t;

    // One key's stored state: mapped code, raw and stable level, last change time.
    typedef struct packed {
        logic [7:0]  code;
        logic        raw;
        logic        stable;
        logic [31:0] ctime;
    } entry_t;

endpackage

// ===== rtl/core/key_matrix_debounce_keymap_top.sv =====
// Top level of the key matrix debouncer with keymap lookup.
// Each transfer on the sample channel is either a key sample or a keymap write and
// yields exactly one transfer on the result channel. The block takes one item per
// cycle unless result_ready stalls it: the accepted item's key entry is read from
// the key store at the accept edge, updated in the update stage (debounce compare
// on the wrapping 32-bit time difference, stable-level change, keymap lookup) and
// written back, while the result goes to an output register. Back-to-back items
// on the same key are served by forwarding the just-written entry inside the key
// store. The held-key count and press total live in registers and update with each
// sample; the reported held count saturates at 31. Keymap entries must be written
// before a sample of that key can change its stable level. The debounce time is
// written via cfg_we/cfg_data, resets to 18; write only while idle (not enforced).
module key_matrix_debounce_keymap_top #(
    parameter int ROW_COUNT = 5,
    parameter int COL_COUNT = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  kmd_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output kmd_pkg::result_t result
);
    import kmd_pkg::*;

    localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
    localparam int IDX_W     = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
    localparam int HELD_W    = $clog2(KEY_TOTAL + 1);
    localparam logic [4:0] ROW_LIM = 5'(ROW_COUNT);
    localparam logic [4:0] COL_LIM = 5'(COL_COUNT);
    localparam logic [4:0] COL_MUL = 5'(COL_COUNT);

    // Configuration
    logic [7:0]        deb_reg;

    // Update stage
    logic              s1_valid_reg;
    sample_t           s1_item_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_inrange_reg;
    logic              s1_adv;

    // Counters
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic [15:0]       press_reg;
    logic [15:0]       press_next;

    // Output register
    logic              result_valid_reg;
    result_t           result_reg;

    // Input decode
    logic              accept;
    logic              in_range;
    logic [8:0]        idx_full;
    logic [IDX_W-1:0]  in_idx;

    // Key store access
    entry_t            cur;
    entry_t            upd;
    logic              wr_en;
    logic [31:0]       elapsed;
    logic [1:0]        ev;
    logic [7:0]        code_out;
    logic [8:0]        held_wide;

    // Advance the update stage whenever the output register is free or draining.
    assign s1_adv       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign accept       = sample_valid && sample_ready;

    assign in_range = ({2'b00, sample.row} < ROW_LIM) && ({2'b00, sample.col} < COL_LIM);
    assign idx_full = {6'd0, sample.row} * {4'd0, COL_MUL} + {6'd0, sample.col};
    assign in_idx   = idx_full[IDX_W-1:0];

    // Out-of-range items leave every key untouched.
    assign wr_en = s1_adv && s1_inrange_reg;

    // Skip the store read for a position outside the matrix.
    kmd_key_store #(
        .KEY_TOTAL (KEY_TOTAL),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_idx  (in_idx),
        .wr_en   (wr_en),
        .wr_idx  (s1_idx_reg),
        .wr_data (upd),
        .rd_data (cur)
    );

    // Read-modify-write of the key entry, debounce decision and event report.
    always_comb
    begin
        upd        = cur;
        ev         = EV_NONE;
        code_out   = 8'd0;
        held_next  = held_reg;
        press_next = press_reg;
        elapsed    = 32'd0;
        if (s1_inrange_reg)
        begin
            if (s1_item_reg.op == OP_MAP_WRITE)
            begin
                upd.code = s1_item_reg.map_code;
            end
            else
            begin
                // Restart the hold timer on a raw level change.
                if (s1_item_reg.key_down != cur.raw)
                begin
                    upd.raw   = s1_item_reg.key_down;
                    upd.ctime = s1_item_reg.now_ms;
                end
                elapsed = s1_item_reg.now_ms - upd.ctime;
                if ((elapsed >= {24'd0, deb_reg}) && (upd.stable != upd.raw))
                begin
                    upd.stable = upd.raw;
                    if (upd.raw)
                    begin
                        held_next = held_reg + HELD_W'(1);
                    end
                    else
                    begin
                        held_next = held_reg - HELD_W'(1);
                    end
                    // A zero code changes the level silently.
                    if (cur.code != 8'd0)
                    begin
                        code_out = cur.code;
                        if (upd.raw)
                        begin
                            ev         = EV_PRESS;
                            press_next = press_reg + 16'd1;
                        end
                        else
                        begin
                            ev = EV_RELEASE;
                        end
                    end
                end
            end
        end
    end

    assign held_wide = 9'(held_next);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg    <= sample;
            s1_idx_reg     <= in_idx;
            s1_inrange_reg <= in_range;
        end
        if (s1_adv)
        begin
            result_reg.event_res    <= ev;
            result_reg.key_code     <= code_out;
            result_reg.active_count <= (held_wide > {4'd0, ACTIVE_MAX}) ?
                                       ACTIVE_MAX : held_wide[4:0];
            result_reg.press_total  <= press_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg          <= DEBOUNCE_RESET;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            held_reg         <= '0;
            press_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                deb_reg <= cfg_data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
                held_reg         <= held_next;
                press_reg        <= press_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, held_reg} <= (HELD_W + 1)'(KEY_TOTAL))
        else $error("held key count exceeds the number of keys");

    a_event_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.event_res != EV_NONE) |-> result_reg.key_code != 8'd0)
        else $error("event reported with a zero key code");

    a_press_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        press_reg != $past(press_reg) |-> $past(s1_adv) && result_reg.event_res == EV_PRESS)
        else $error("press total moved without a reported press");
`endif

endmodule

// ===== rtl/core/kmd_key_store.sv =====
// Per-key state memory with valid bits and write-to-read forwarding.
module kmd_key_store #(
    parameter int KEY_TOTAL = 25,
    parameter int IDX_W     = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_idx,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  kmd_pkg::entry_t    wr_data,
    output kmd_pkg::entry_t    rd_data
);
    import kmd_pkg::*;

    entry_t               mem [KEY_TOTAL];
    logic [KEY_TOTAL-1:0] vld_reg;
    entry_t               mem_q_reg;
    logic                 vld_q_reg;
    logic                 fwd_hit_reg;
    entry_t               fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_q_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg   <= vld_reg[rd_idx];
                fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
            end
        end
    end

    // An entry never written reads as the reset state (all zero).
    assign rd_data = fwd_hit_reg ? fwd_data_reg : (vld_q_reg ? mem_q_reg : '0);

`ifndef ASSERT_OFF
    a_forward_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (rd_idx == wr_idx) |=> rd_data == $past(wr_data))
        else $error("read of an entry written in the same cycle missed the new data");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_idx)])
        else $error("written entry not marked valid");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> {1'b0, rd_idx} < (IDX_W + 1)'(KEY_TOTAL))
        else $error("read of an entry beyond the last key");
`endif

endmodule
